// File: rtl/telnet_option_negotiator_core_assert.svh
// assertion macros for the negotiator rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef TELNET_OPTION_NEGOTIATOR_CORE_ASSERT_SVH
`define TELNET_OPTION_NEGOTIATOR_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define TONC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tonc assertion failed");

// next-cycle implication, held off during reset
`define TONC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tonc assertion failed");

`endif

// File: rtl/tonc_pkg.sv
// shared types and codes for the telnet option negotiator
// no dependencies
package tonc_pkg;

  // telnet command codes
  localparam logic [7:0] CODE_IAC  = 8'd255;
  localparam logic [7:0] CODE_WILL = 8'd251;
  localparam logic [7:0] CODE_WONT = 8'd252;
  localparam logic [7:0] CODE_DO   = 8'd253;
  localparam logic [7:0] CODE_DONT = 8'd254;

  // option codes that are ever accepted
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;

  // highest option code treated as known when answering wont and dont
  localparam logic [7:0] OPTION_LIMIT = 8'd6;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENY_ECHO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CR_NUL    = 1'b1;

  // what the back end has to emit for one item
  typedef enum logic [1:0] {
    JOB_ONE,    // single byte
    JOB_CRNUL,  // typed cr then nul
    JOB_REPLY   // iac, ack, option
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;    // the byte, or the option code of a reply
    logic [7:0] ack;     // verb of a reply
    logic       to_net;
    logic       echo;    // remote echo flag after the item
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// File: rtl/tonc_front.sv
// front end: parses bytes, keeps option flags and config, builds jobs
// depends on tonc_pkg
module tonc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic                              in_action,
  input  logic [7:0]                        in_byte,
  input  logic                              q_full,
  input  logic                              cfg_valid,
  input  logic [tonc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                              cfg_data,
  output logic                              job_push,
  output tonc_pkg::job_t                    job
);
  import tonc_pkg::*;

  typedef enum logic [1:0] {PH_DATA, PH_CMD, PH_OPT} phase_t;

  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_WONT = 2'd1;
  localparam logic [1:0] VERB_DO   = 2'd2;
  localparam logic [1:0] VERB_DONT = 2'd3;

  phase_t     phase_r, phase_nxt;
  logic [1:0] verb_r, verb_nxt;
  logic       rem_bin_r, rem_bin_nxt;
  logic       rem_echo_r, rem_echo_nxt;
  logic       rem_sga_r, rem_sga_nxt;
  logic       loc_sga_r, loc_sga_nxt;
  logic       deny_echo_r;
  logic       cr_nul_r;

  logic       accept;
  logic       is_verb;
  logic       known;
  logic       rem_opt;
  logic       rem_cur;
  logic       loc_cur;
  logic [7:0] verb_diff;

  assign accept    = in_push && !q_full;
  assign is_verb   = (in_byte >= CODE_WILL) && (in_byte <= CODE_DONT);
  assign verb_diff = in_byte - CODE_WILL;
  assign known     = in_byte <= OPTION_LIMIT;
  // only binary, echo and sga can ever hold a remote flag, only sga a local one
  assign rem_opt   = (in_byte == OPT_BINARY) || (in_byte == OPT_ECHO) ||
                     (in_byte == OPT_SGA);
  assign rem_cur   = ((in_byte == OPT_BINARY) && rem_bin_r) ||
                     ((in_byte == OPT_ECHO) && rem_echo_r) ||
                     ((in_byte == OPT_SGA) && rem_sga_r);
  assign loc_cur   = (in_byte == OPT_SGA) && loc_sga_r;

  always_comb begin
    phase_nxt    = phase_r;
    verb_nxt     = verb_r;
    rem_bin_nxt  = rem_bin_r;
    rem_echo_nxt = rem_echo_r;
    rem_sga_nxt  = rem_sga_r;
    loc_sga_nxt  = loc_sga_r;
    job_push     = 1'b0;
    job.kind     = JOB_ONE;
    job.data     = in_byte;
    job.ack      = CHAR_NUL;
    job.to_net   = 1'b0;
    if (accept) begin
      if (in_action) begin
        // keyboard byte, parse state untouched
        job_push   = 1'b1;
        job.to_net = 1'b1;
        if ((in_byte == CHAR_CR) && cr_nul_r) begin
          job.kind = JOB_CRNUL;
        end
      end else begin
        unique case (phase_r)
          PH_CMD: begin
            if (is_verb) begin
              verb_nxt  = verb_diff[1:0];
              phase_nxt = PH_OPT;
            end else begin
              phase_nxt = PH_DATA;
              // doubled iac is a literal 255, other commands are dropped
              job_push  = in_byte == CODE_IAC;
            end
          end
          PH_OPT: begin
            phase_nxt  = PH_DATA;
            job.kind   = JOB_REPLY;
            job.to_net = 1'b1;
            unique case (verb_r)
              VERB_WILL: begin
                if (!rem_opt) begin
                  job_push = 1'b1;
                  job.ack  = CODE_DONT;
                end else if (!rem_cur) begin
                  job_push = 1'b1;
                  if ((in_byte == OPT_ECHO) && deny_echo_r) begin
                    job.ack = CODE_DONT;
                  end else begin
                    job.ack = CODE_DO;
                    if (in_byte == OPT_BINARY) rem_bin_nxt = 1'b1;
                    if (in_byte == OPT_ECHO)   rem_echo_nxt = 1'b1;
                    if (in_byte == OPT_SGA)    rem_sga_nxt = 1'b1;
                  end
                end
              end
              VERB_WONT: begin
                job.ack = CODE_DONT;
                if (!known) begin
                  job_push = 1'b1;
                end else if (rem_cur) begin
                  job_push = 1'b1;
                  if (in_byte == OPT_BINARY) rem_bin_nxt = 1'b0;
                  if (in_byte == OPT_ECHO)   rem_echo_nxt = 1'b0;
                  if (in_byte == OPT_SGA)    rem_sga_nxt = 1'b0;
                end
              end
              VERB_DO: begin
                if (in_byte != OPT_SGA) begin
                  job_push = 1'b1;
                  job.ack  = CODE_WONT;
                end else if (!loc_sga_r) begin
                  job_push    = 1'b1;
                  job.ack     = CODE_WILL;
                  loc_sga_nxt = 1'b1;
                end
              end
              VERB_DONT: begin
                job.ack = CODE_WONT;
                if (!known) begin
                  job_push = 1'b1;
                end else if (loc_cur) begin
                  job_push    = 1'b1;
                  loc_sga_nxt = 1'b0;
                end
              end
              default: ;
            endcase
          end
          default: begin
            if (in_byte == CODE_IAC) begin
              phase_nxt = PH_CMD;
            end else begin
              phase_nxt = PH_DATA;
              job_push  = 1'b1;
            end
          end
        endcase
      end
    end
    job.echo = rem_echo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      verb_r      <= VERB_WILL;
      rem_bin_r   <= 1'b0;
      rem_echo_r  <= 1'b0;
      rem_sga_r   <= 1'b0;
      loc_sga_r   <= 1'b0;
      deny_echo_r <= 1'b0;
      cr_nul_r    <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      verb_r     <= verb_nxt;
      rem_bin_r  <= rem_bin_nxt;
      rem_echo_r <= rem_echo_nxt;
      rem_sga_r  <= rem_sga_nxt;
      loc_sga_r  <= loc_sga_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DENY_ECHO: deny_echo_r <= cfg_data;
          CFG_CR_NUL:    cr_nul_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/tonc_queue.sv
// job queue between front and back end
// depends on tonc_pkg
module tonc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tonc_pkg::job_t     wr_job,
  input  logic               pop,
  output tonc_pkg::job_t     rd_job,
  output tonc_pkg::q_stat_t  stat
);
  import tonc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat.empty = count_r == '0;
  assign stat.full  = count_r == CNT_FULL;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/tonc_back.sv
// back end: expands each job into result bytes through an output register
// depends on tonc_pkg
module tonc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  tonc_pkg::job_t  head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_byte,
  output logic            out_to_network,
  output logic            out_last,
  output logic            out_remote_echo
);
  import tonc_pkg::*;

  logic [1:0] seq_r, seq_nxt;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       net_r;
  logic       last_r;
  logic       echo_r;
  logic       load;
  logic [7:0] el_byte;
  logic       el_last;

  assign load = !q_empty && (!out_valid_r || out_pop);

  // pick the element of the head job that seq_r points at
  always_comb begin
    el_byte = head.data;
    el_last = 1'b1;
    unique case (head.kind)
      JOB_ONE: ;
      JOB_CRNUL: begin
        el_last = seq_r != 2'd0;
        el_byte = (seq_r == 2'd0) ? head.data : CHAR_NUL;
      end
      JOB_REPLY: begin
        el_last = seq_r == 2'd2;
        unique case (seq_r)
          2'd0:    el_byte = CODE_IAC;
          2'd1:    el_byte = head.ack;
          default: el_byte = head.data;
        endcase
      end
      default: ;
    endcase
  end

  assign q_pop   = load && el_last;
  assign seq_nxt = !load ? seq_r : (el_last ? 2'd0 : seq_r + 2'd1);

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= el_byte;
      net_r  <= head.to_net;
      last_r <= el_last;
      echo_r <= head.echo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_byte        = byte_r;
  assign out_to_network  = net_r;
  assign out_last        = last_r;
  assign out_remote_echo = echo_r;

endmodule

// File: rtl/telnet_option_negotiator_core.sv
// telnet option negotiator, top level
// instantiates tonc_front, tonc_queue and tonc_back; uses tonc_pkg and the assert header
//
// channel   direction  handshake            payload
// in_       input      push / full          in_action, in_byte
// out_      output     empty / pop          out_byte, out_to_network, out_last,
//                                           out_remote_echo
// cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one input item can be taken every cycle while the job queue is not full; each result
// byte leaves the output register on its own, so a job gives one byte, two for cr plus nul
// and three for a negotiation reply, and the job queue of QUEUE_DEPTH entries absorbs that
// first result of an item goes into the job queue, then into the output register
// in_full is high exactly while the job queue is full; cfg_ready is always high
// synchronous reset clears parse state, option flags and config, and empties the queue
module telnet_option_negotiator_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_action,
  input  logic [7:0]                        in_byte,
  // result channel
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [7:0]                        out_byte,
  output logic                              out_to_network,
  output logic                              out_last,
  output logic                              out_remote_echo,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tonc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                              cfg_data
);
  import tonc_pkg::*;
  `include "telnet_option_negotiator_core_assert.svh"

  job_t    fr_job;
  logic    fr_push;
  job_t    q_head;
  logic    q_pop;
  q_stat_t q_stat;

  // config writes never wait
  assign cfg_ready = 1'b1;
  assign in_full   = q_stat.full;

  // front: parse and negotiate, one transaction per cycle while the job queue has room
  tonc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_action (in_action),
    .in_byte   (in_byte),
    .q_full    (q_stat.full),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_push  (fr_push),
    .job       (fr_job)
  );

  // decouples the parser from result delivery
  tonc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fr_push),
    .wr_job (fr_job),
    .pop    (q_pop),
    .rd_job (q_head),
    .stat   (q_stat)
  );

  // back: one result byte per cycle into the output register while it is free or popped and the job queue is not empty
  tonc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .q_empty         (q_stat.empty),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_to_network  (out_to_network),
    .out_last        (out_last),
    .out_remote_echo (out_remote_echo)
  );

  // results bound for the terminal are always alone in their transaction
  `TONC_ASSERT_IMPLY(a_term_single, !out_empty && !out_to_network, out_last)
  // a keyboard byte always leaves a job queued
  `TONC_ASSERT_NEXT(a_key_queued, in_push && !in_full && in_action, !q_stat.empty)
  // the rest of a multi-byte result follows right behind
  `TONC_ASSERT_NEXT(a_burst_cont, out_pop && !out_empty && !out_last, !out_empty)
  // nothing appears at the output without a queued job
  `TONC_ASSERT_NEXT(a_no_invent, q_stat.empty && out_empty, out_empty)

endmodule
